// ----- src/mdu_pkg.sv -----
// shared constants, types and helpers of the mahalanobis distance unit
// depends on nothing; used by mdu_divsqrt and the top level
package mdu_pkg;

  localparam int MAX_DIM    = 16;
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int MAT_DEPTH  = 2 ** (2 * IDX_W);
  localparam int IN_DATA_W  = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int STEP_W     = 7;

  typedef enum logic [1:0] {
    CMD_MAT     = 2'd0,
    CMD_MEAN    = 2'd1,
    CMD_SAMPLE  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACT = 2'd1;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh7FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sh80000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [2*IDX_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return {r, c};
  endfunction

endpackage

// ----- src/mdu_ram.sv -----
// generic single write, single read ram with registered read data
// depends on nothing
module mdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mdu_divsqrt.sv -----
// shared iterative unit: restoring 64/32 divide or 64-bit integer square root
// one bit per cycle; depends on mdu_pkg
module mdu_divsqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  mdu_pkg::unit_req_t  req,
  input  logic [63:0]         opnd,
  input  logic [31:0]         divisor,
  output mdu_pkg::unit_sts_t  sts,
  output logic [63:0]         quo,
  output logic [31:0]         root
);

  logic                        busy_r;
  logic                        done_r;
  logic [mdu_pkg::STEP_W-1:0]  cnt_r;
  logic                        sqrt_r;
  logic [34:0]                 rem_r;
  logic [63:0]                 shf_r;
  logic [31:0]                 root_r;
  logic [31:0]                 div_r;

  logic [32:0] trial_d;
  logic [34:0] trial_s;
  logic [34:0] cand_s;
  logic        ge;
  logic [34:0] rem_nxt;
  logic [63:0] shf_nxt;
  logic [31:0] root_nxt;

  always_comb begin
    trial_d  = {rem_r[31:0], shf_r[63]};
    trial_s  = {rem_r[32:0], shf_r[63:62]};
    cand_s   = {1'b0, root_r, 2'b01};
    root_nxt = root_r;
    if (sqrt_r) begin
      ge       = (trial_s >= cand_s);
      rem_nxt  = ge ? (trial_s - cand_s) : trial_s;
      root_nxt = {root_r[30:0], ge};
      shf_nxt  = {shf_r[61:0], 2'b00};
    end else begin
      ge      = (trial_d >= {1'b0, div_r});
      rem_nxt = {2'b00, (ge ? (trial_d - {1'b0, div_r}) : trial_d)};
      shf_nxt = {shf_r[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.is_sqrt ? mdu_pkg::STEP_W'(mdu_pkg::SQRT_STEPS)
                              : mdu_pkg::STEP_W'(mdu_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mdu_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sqrt_r <= req.is_sqrt;
      rem_r  <= '0;
      shf_r  <= opnd;
      root_r <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      shf_r  <= shf_nxt;
      root_r <= root_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = shf_r;
  assign root     = root_r;

endmodule

// ----- src/mahalanobis_distance_unit.sv -----
// top level: load stores, cholesky factoring, projection and norm of the mahalanobis distance
// depends on mdu_pkg, mdu_ram and mdu_divsqrt
//
//   channel  dir  handshake           payload
//   in_      in   in_tvalid/tready    tdata {value,col,row}, tuser command
//   out_     out  out_tvalid/tready   tdata distance, tuser not_positive_definite
//   cfg_     in   cfg_valid/ready     cfg_index, cfg_data
//
// load items are taken one per cycle while idle and write straight into the stores
// a compute item takes longer when factoring than when already factored, and ends early when
// factoring fails; its pace is set by the one-bit-per-cycle divide/root unit and the single
// shared multiplier
// in_tready is low meanwhile, and longer while the previous result is not yet taken
// a finished result waits in the output register; reset is synchronous, active low
module mahalanobis_distance_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mdu_pkg::IN_DATA_W-1:0]     in_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [1:0]                        in_tuser,   // command[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // distance[31:0]
  output logic [0:0]                        out_tuser,  // not_positive_definite[0]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW = mdu_pkg::IDX_W;
  localparam int CW = mdu_pkg::CNT_W;

  typedef enum logic [25:0] {
    S_IDLE      = 26'h0000001,
    S_DIFF_RD   = 26'h0000002,
    S_DIFF_WR   = 26'h0000004,
    S_F_COL     = 26'h0000008,
    S_SQ_RD     = 26'h0000010,
    S_SQ_MUL    = 26'h0000020,
    S_SQ_ACC    = 26'h0000040,
    S_DIAG_RD   = 26'h0000080,
    S_DIAG_CHK  = 26'h0000100,
    S_DIAG_SQRT = 26'h0000200,
    S_OFF_INIT  = 26'h0000400,
    S_OFF_RDA   = 26'h0000800,
    S_OFF_RDB   = 26'h0001000,
    S_OFF_MUL   = 26'h0002000,
    S_OFF_ACC   = 26'h0004000,
    S_OFF_MRD   = 26'h0008000,
    S_OFF_DIV   = 26'h0010000,
    S_OFF_WAIT  = 26'h0020000,
    S_P_ROW     = 26'h0040000,
    S_P_RD      = 26'h0080000,
    S_P_MUL     = 26'h0100000,
    S_P_ACC     = 26'h0200000,
    S_P_MAG     = 26'h0400000,
    S_P_SQ      = 26'h0800000,
    S_ROOT      = 26'h1000000,
    S_DONE      = 26'h2000000
  } state_t;

  state_t st_r, st_nxt;

  logic [4:0]           dims_r;
  logic                 af_r;
  logic [CW-1:0]        n_r, n_nxt, j_r, j_nxt, i_r, i_nxt, k_r, k_nxt;
  logic signed [63:0]   acc_r, acc_nxt;
  logic [31:0]          piv_r, piv_nxt, opa_r, opa_nxt;
  logic                 neg_r, neg_nxt;
  logic [63:0]          sum_r, sum_nxt;
  logic [31:0]          res_dist_r, res_dist_nxt;
  logic                 res_npd_r, res_npd_nxt;
  logic signed [63:0]   prod_r;
  logic                 out_tvalid_r;
  logic [31:0]          out_dist_r;
  logic                 out_npd_r;
  logic                 out_load;

  mdu_pkg::cmd_t        in_cmd;
  logic [3:0]           in_row, in_col;
  logic [31:0]          in_value;
  logic                 in_acc, row_ok, col_ok;
  logic [CW-1:0]        n_eff;

  logic [31:0]          mat_rd, fac_rd, mean_rd, smp_rd, dif_rd;
  logic [2*IW-1:0]      mat_raddr, fac_raddr, fac_waddr;
  logic                 fac_we, dif_we;
  logic [31:0]          fac_wdata, dif_wdata;

  mdu_pkg::unit_req_t   req;
  mdu_pkg::unit_sts_t   sts;
  logic [63:0]          unit_opnd, quo;
  logic [31:0]          root;

  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   mul_p;
  logic signed [63:0]   s_val, s_abs, acc_abs;
  logic [47:0]          mag;
  logic [64:0]          sum_add;
  logic [31:0]          root_sat, quo_sat;
  logic [CW-1:0]        k_inc, i_inc, j_inc;
  logic [31:0]          u_rd;

  assign in_cmd   = mdu_pkg::cmd_t'(in_tuser);
  assign in_row   = in_tdata[3:0];
  assign in_col   = in_tdata[7:4];
  assign in_value = in_tdata[39:8];
  assign in_acc   = in_tvalid & in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign row_ok   = ({28'd0, in_row} < 32'(mdu_pkg::MAX_DIM));
  assign col_ok   = ({28'd0, in_col} < 32'(mdu_pkg::MAX_DIM));
  assign cfg_ready = 1'b1;

  always_comb begin
    if (dims_r == 5'd0) begin
      n_eff = CW'(1);
    end else if ({27'd0, dims_r} > 32'(mdu_pkg::MAX_DIM)) begin
      n_eff = CW'(mdu_pkg::MAX_DIM);
    end else begin
      n_eff = CW'(dims_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 5'd16;
      af_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mdu_pkg::CFG_DIMS) begin
        dims_r <= cfg_data[4:0];
      end else if (cfg_index == mdu_pkg::CFG_FACT) begin
        af_r <= cfg_data[0];
      end
    end
  end

  // stores
  mdu_ram #(.WIDTH(32), .DEPTH(mdu_pkg::MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (in_acc && in_cmd == mdu_pkg::CMD_MAT && row_ok && col_ok),
    .waddr (mdu_pkg::mat_addr(IW'(in_row), IW'(in_col))),
    .wdata (in_value),
    .raddr (mat_raddr),
    .rdata (mat_rd)
  );

  mdu_ram #(.WIDTH(32), .DEPTH(mdu_pkg::MAT_DEPTH)) u_fac_ram (
    .clk   (clk),
    .we    (fac_we),
    .waddr (fac_waddr),
    .wdata (fac_wdata),
    .raddr (fac_raddr),
    .rdata (fac_rd)
  );

  mdu_ram #(.WIDTH(32), .DEPTH(mdu_pkg::MAX_DIM)) u_mean_ram (
    .clk   (clk),
    .we    (in_acc && in_cmd == mdu_pkg::CMD_MEAN && row_ok),
    .waddr (IW'(in_row)),
    .wdata (in_value),
    .raddr (k_r[IW-1:0]),
    .rdata (mean_rd)
  );

  mdu_ram #(.WIDTH(32), .DEPTH(mdu_pkg::MAX_DIM)) u_smp_ram (
    .clk   (clk),
    .we    (in_acc && in_cmd == mdu_pkg::CMD_SAMPLE && row_ok),
    .waddr (IW'(in_row)),
    .wdata (in_value),
    .raddr (k_r[IW-1:0]),
    .rdata (smp_rd)
  );

  mdu_ram #(.WIDTH(32), .DEPTH(mdu_pkg::MAX_DIM)) u_dif_ram (
    .clk   (clk),
    .we    (dif_we),
    .waddr (k_r[IW-1:0]),
    .wdata (dif_wdata),
    .raddr (k_r[IW-1:0]),
    .rdata (dif_rd)
  );

  mdu_divsqrt u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .opnd    (unit_opnd),
    .divisor (piv_r),
    .sts     (sts),
    .quo     (quo),
    .root    (root)
  );

  // shared multiplier, registered
  assign mul_p = mul_a * mul_b;
  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
  end

  assign dif_wdata = mdu_pkg::sat32({{32{smp_rd[31]}}, smp_rd} - {{32{mean_rd[31]}}, mean_rd});
  assign s_val     = mdu_pkg::sat_add64({{16{mat_rd[31]}}, mat_rd, 16'd0}, -acc_r);
  assign s_abs     = s_val[63] ? -s_val : s_val;
  assign acc_abs   = acc_r[63] ? -acc_r : acc_r;
  assign mag       = acc_abs[63:16];
  assign sum_add   = {1'b0, sum_r} + {1'b0, prod_r};
  assign root_sat  = root[31] ? 32'h7FFFFFFF : root;
  assign u_rd      = af_r ? mat_rd : fac_rd;
  assign k_inc     = CW'(k_r + 1'b1);
  assign i_inc     = CW'(i_r + 1'b1);
  assign j_inc     = CW'(j_r + 1'b1);

  always_comb begin
    if (neg_r) begin
      quo_sat = (quo > 64'h80000000) ? 32'h80000000 : (~quo[31:0] + 32'd1);
    end else begin
      quo_sat = (quo > 64'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
    end
  end

  always_comb begin
    st_nxt       = st_r;
    n_nxt        = n_r;
    j_nxt        = j_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    acc_nxt      = acc_r;
    piv_nxt      = piv_r;
    opa_nxt      = opa_r;
    neg_nxt      = neg_r;
    sum_nxt      = sum_r;
    res_dist_nxt = res_dist_r;
    res_npd_nxt  = res_npd_r;
    fac_we       = 1'b0;
    fac_waddr    = mdu_pkg::mat_addr(j_r[IW-1:0], i_r[IW-1:0]);
    fac_wdata    = quo_sat;
    dif_we       = 1'b0;
    req          = '0;
    unit_opnd    = sum_r;
    mat_raddr    = mdu_pkg::mat_addr(i_r[IW-1:0], k_r[IW-1:0]);
    fac_raddr    = mdu_pkg::mat_addr(i_r[IW-1:0], k_r[IW-1:0]);
    mul_a        = '0;
    mul_b        = '0;
    out_load     = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc && in_cmd == mdu_pkg::CMD_COMPUTE) begin
          n_nxt   = n_eff;
          k_nxt   = '0;
          sum_nxt = '0;
          st_nxt  = S_DIFF_RD;
        end
      end
      S_DIFF_RD: st_nxt = S_DIFF_WR;
      S_DIFF_WR: begin
        dif_we = 1'b1;
        k_nxt  = k_inc;
        if (k_inc == n_r) begin
          if (af_r) begin
            i_nxt  = '0;
            st_nxt = S_P_ROW;
          end else begin
            j_nxt  = '0;
            st_nxt = S_F_COL;
          end
        end else begin
          st_nxt = S_DIFF_RD;
        end
      end
      S_F_COL: begin
        acc_nxt = '0;
        k_nxt   = '0;
        if (j_r == n_r) begin
          i_nxt  = '0;
          st_nxt = S_P_ROW;
        end else if (j_r != '0) begin
          st_nxt = S_SQ_RD;
        end else begin
          st_nxt = S_DIAG_RD;
        end
      end
      S_SQ_RD: begin
        fac_raddr = mdu_pkg::mat_addr(k_r[IW-1:0], j_r[IW-1:0]);
        st_nxt    = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        mul_a  = {fac_rd[31], fac_rd};
        mul_b  = {fac_rd[31], fac_rd};
        st_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        acc_nxt = mdu_pkg::sat_add64(acc_r, prod_r);
        k_nxt   = k_inc;
        st_nxt  = (k_inc < j_r) ? S_SQ_RD : S_DIAG_RD;
      end
      S_DIAG_RD: begin
        mat_raddr = mdu_pkg::mat_addr(j_r[IW-1:0], j_r[IW-1:0]);
        st_nxt    = S_DIAG_CHK;
      end
      S_DIAG_CHK: begin
        if (s_val[63] || s_val == 64'sd0) begin
          res_dist_nxt = '0;
          res_npd_nxt  = 1'b1;
          st_nxt       = S_DONE;
        end else begin
          req.start   = 1'b1;
          req.is_sqrt = 1'b1;
          unit_opnd   = s_val;
          st_nxt      = S_DIAG_SQRT;
        end
      end
      S_DIAG_SQRT: begin
        if (sts.done) begin
          fac_we    = 1'b1;
          fac_waddr = mdu_pkg::mat_addr(j_r[IW-1:0], j_r[IW-1:0]);
          fac_wdata = root_sat;
          piv_nxt   = root_sat;
          i_nxt     = j_inc;
          if (j_inc < n_r) begin
            st_nxt = S_OFF_INIT;
          end else begin
            j_nxt  = j_inc;
            st_nxt = S_F_COL;
          end
        end
      end
      S_OFF_INIT: begin
        acc_nxt = '0;
        k_nxt   = '0;
        st_nxt  = (j_r != '0) ? S_OFF_RDA : S_OFF_MRD;
      end
      S_OFF_RDA: begin
        fac_raddr = mdu_pkg::mat_addr(k_r[IW-1:0], j_r[IW-1:0]);
        st_nxt    = S_OFF_RDB;
      end
      S_OFF_RDB: begin
        opa_nxt   = fac_rd;
        fac_raddr = mdu_pkg::mat_addr(k_r[IW-1:0], i_r[IW-1:0]);
        st_nxt    = S_OFF_MUL;
      end
      S_OFF_MUL: begin
        mul_a  = {opa_r[31], opa_r};
        mul_b  = {fac_rd[31], fac_rd};
        st_nxt = S_OFF_ACC;
      end
      S_OFF_ACC: begin
        acc_nxt = mdu_pkg::sat_add64(acc_r, prod_r);
        k_nxt   = k_inc;
        st_nxt  = (k_inc < j_r) ? S_OFF_RDA : S_OFF_MRD;
      end
      S_OFF_MRD: begin
        mat_raddr = mdu_pkg::mat_addr(j_r[IW-1:0], i_r[IW-1:0]);
        st_nxt    = S_OFF_DIV;
      end
      S_OFF_DIV: begin
        req.start = 1'b1;
        unit_opnd = s_abs;
        neg_nxt   = s_val[63];
        st_nxt    = S_OFF_WAIT;
      end
      S_OFF_WAIT: begin
        if (sts.done) begin
          fac_we = 1'b1;
          i_nxt  = i_inc;
          if (i_inc < n_r) begin
            st_nxt = S_OFF_INIT;
          end else begin
            j_nxt  = j_inc;
            st_nxt = S_F_COL;
          end
        end
      end
      S_P_ROW: begin
        acc_nxt = '0;
        k_nxt   = i_r;
        if (i_r == n_r) begin
          req.start   = 1'b1;
          req.is_sqrt = 1'b1;
          st_nxt      = S_ROOT;
        end else begin
          st_nxt = S_P_RD;
        end
      end
      S_P_RD: st_nxt = S_P_MUL;
      S_P_MUL: begin
        mul_a  = {u_rd[31], u_rd};
        mul_b  = {dif_rd[31], dif_rd};
        st_nxt = S_P_ACC;
      end
      S_P_ACC: begin
        acc_nxt = mdu_pkg::sat_add64(acc_r, prod_r);
        k_nxt   = k_inc;
        st_nxt  = (k_inc < n_r) ? S_P_RD : S_P_MAG;
      end
      S_P_MAG: begin
        if (mag[47:32] != 16'd0) begin
          res_dist_nxt = 32'hFFFFFFFF;
          res_npd_nxt  = 1'b0;
          st_nxt       = S_DONE;
        end else begin
          mul_a  = {1'b0, mag[31:0]};
          mul_b  = {1'b0, mag[31:0]};
          st_nxt = S_P_SQ;
        end
      end
      S_P_SQ: begin
        if (sum_add[64]) begin
          res_dist_nxt = 32'hFFFFFFFF;
          res_npd_nxt  = 1'b0;
          st_nxt       = S_DONE;
        end else begin
          sum_nxt = sum_add[63:0];
          i_nxt   = i_inc;
          st_nxt  = S_P_ROW;
        end
      end
      S_ROOT: begin
        if (sts.done) begin
          res_dist_nxt = root;
          res_npd_nxt  = 1'b0;
          st_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    piv_r      <= piv_nxt;
    opa_r      <= opa_nxt;
    neg_r      <= neg_nxt;
    sum_r      <= sum_nxt;
    res_dist_r <= res_dist_nxt;
    res_npd_r  <= res_npd_nxt;
    if (out_load) begin
      out_dist_r <= res_dist_r;
      out_npd_r  <= res_npd_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_dist_r;
  assign out_tuser[0] = out_npd_r;

`ifndef SYNTHESIS
  a_npd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 32'd0))
    else $error("failed factoring with nonzero distance");

  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !sts.busy)
    else $error("shared unit started while busy");

  a_piv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && !req.is_sqrt) |-> (piv_r != 32'd0))
    else $error("divide by zero pivot");

  a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == mdu_pkg::CMD_COMPUTE) |=> !in_tready)
    else $error("compute item did not stall input");
`endif

endmodule
